[hdl/fsp_pkg.sv]
// Format specifier parser package: widths, character codes, phase encoding,
// notation codes and the structs passed between the parser modules.
// No dependencies.
package fsp_pkg;

   localparam int CHAR_W  = 8;
   localparam int ACC_W   = 16;
   localparam int PREC_W  = ACC_W + 1;
   localparam int DIGIT_W = 4;
   localparam int MAC_W   = ACC_W + 4;
   localparam int FM_W    = 3;
   localparam int IM_W    = 2;

   localparam logic [ACC_W-1:0] ACC_SAT = {ACC_W{1'b1}};

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;

   typedef enum logic [3:0] {
      PH_FLAGS = 4'b0001,
      PH_WIDTH = 4'b0010,
      PH_DOT   = 4'b0100,
      PH_PREC  = 4'b1000
   } phase_type;

   typedef enum logic [FM_W-1:0] {
      FM_FIXED     = 3'd0,
      FM_FIXED_REL = 3'd1,
      FM_EXPONENT  = 3'd2,
      FM_ENGINEER  = 3'd3,
      FM_SMART     = 3'd4,
      FM_COMPACT   = 3'd5
   } float_mode_type;

   typedef enum logic [IM_W-1:0] {
      IM_DECIMAL = 2'd0,
      IM_HEX     = 2'd1,
      IM_OCTAL   = 2'd2,
      IM_BINARY  = 2'd3
   } int_mode_type;

   typedef struct packed {
      logic pad;
      logic left;
      logic zero;
      logic full;
   } flags_type;

   typedef struct packed {
      logic           hit;
      float_mode_type float_mode;
      int_mode_type   int_mode;
      logic           zero;
      logic           full;
   } type_info_type;

endpackage

[hdl/fsp_if.sv]
// Valid/ready channel interfaces of the format specifier parser:
// one character per request transfer, one parsed specifier per response.
// Depends on fsp_pkg.
interface fsp_req_if;
   logic                        valid;
   logic                        ready;
   logic [fsp_pkg::CHAR_W-1:0]  character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface fsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ok;
   logic                        pad_mark;
   logic                        left_align;
   logic                        zero_fill;
   logic                        full_notation;
   logic [fsp_pkg::FM_W-1:0]    float_mode;
   logic [fsp_pkg::IM_W-1:0]    int_mode;
   logic [fsp_pkg::ACC_W-1:0]   width;
   logic signed [fsp_pkg::PREC_W-1:0] precision;

   modport source (output valid, output ok, output pad_mark, output left_align,
                   output zero_fill, output full_notation, output float_mode,
                   output int_mode, output width, output precision, input ready);
   modport sink   (input valid, input ok, input pad_mark, input left_align,
                   input zero_fill, input full_notation, input float_mode,
                   input int_mode, input width, input precision, output ready);
endinterface

[hdl/fsp_type_dec.sv]
// Type character decoder: maps a conversion character to its notation codes
// and the extra flags implied by the pointer type. Depends on fsp_pkg.
module fsp_type_dec (
   input  logic [fsp_pkg::CHAR_W-1:0] character,
   output fsp_pkg::type_info_type     info
);

   always_comb begin
      info            = '0;
      info.float_mode = fsp_pkg::FM_FIXED;
      info.int_mode   = fsp_pkg::IM_DECIMAL;
      case (character)
         "d", "i", "u", "s", "c", "f": info.hit = 1'b1;
         "F": begin
            info.hit        = 1'b1;
            info.float_mode = fsp_pkg::FM_FIXED_REL;
         end
         "e": begin
            info.hit        = 1'b1;
            info.float_mode = fsp_pkg::FM_EXPONENT;
         end
         "E": begin
            info.hit        = 1'b1;
            info.float_mode = fsp_pkg::FM_ENGINEER;
         end
         "g": begin
            info.hit        = 1'b1;
            info.float_mode = fsp_pkg::FM_SMART;
         end
         "G": begin
            info.hit        = 1'b1;
            info.float_mode = fsp_pkg::FM_COMPACT;
         end
         "a", "x": begin
            info.hit      = 1'b1;
            info.int_mode = fsp_pkg::IM_HEX;
         end
         "p": begin
            info.hit      = 1'b1;
            info.int_mode = fsp_pkg::IM_HEX;
            info.zero     = 1'b1;
            info.full     = 1'b1;
         end
         "o": begin
            info.hit      = 1'b1;
            info.int_mode = fsp_pkg::IM_OCTAL;
         end
         "b": begin
            info.hit      = 1'b1;
            info.int_mode = fsp_pkg::IM_BINARY;
         end
         default: info.hit = 1'b0;
      endcase
   end

endmodule

[hdl/fsp_sat_mac.sv]
// Saturating decimal accumulate: acc * 10 + digit, clipped to the
// accumulator maximum. Shift-and-add, no multiplier. Depends on fsp_pkg.
module fsp_sat_mac (
   input  logic [fsp_pkg::ACC_W-1:0]   acc,
   input  logic [fsp_pkg::DIGIT_W-1:0] digit,
   output logic [fsp_pkg::ACC_W-1:0]   result
);

   logic [fsp_pkg::MAC_W-1:0] sum;

   always_comb begin
      sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
            + {{(fsp_pkg::MAC_W-fsp_pkg::DIGIT_W){1'b0}}, digit};
      if (sum > {{(fsp_pkg::MAC_W-fsp_pkg::ACC_W){1'b0}}, fsp_pkg::ACC_SAT}) begin
         result = fsp_pkg::ACC_SAT;
      end else begin
         result = sum[fsp_pkg::ACC_W-1:0];
      end
   end

endmodule

[hdl/format_spec_parser.sv]
// Printf-style format specifier parser, one character per request transfer.
// Depends on fsp_pkg, fsp_if, fsp_type_dec and fsp_sat_mac.
//
// Each accepted character updates the parse state in the cycle it is taken;
// a character that ends a specifier (type character, NUL or anything else)
// loads the response register, which presents the result in the next cycle.
// The parser takes one character every cycle; the only stall is a held
// response while the response side is not ready, set by the single output
// register.
// Flag, width and precision state clears after each ending character.
module format_spec_parser (
   input  logic            clock,
   input  logic            reset,
   fsp_req_if.sink         req_ch,
   fsp_rsp_if.source       rsp_ch
);

   fsp_pkg::phase_type          phase_ff, phase_in;
   fsp_pkg::flags_type          flags_ff, flags_in;
   logic [fsp_pkg::ACC_W-1:0]   width_acc_ff, width_acc_in;
   logic [fsp_pkg::ACC_W-1:0]   prec_acc_ff, prec_acc_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        ok_ff, ok_in;
   fsp_pkg::flags_type          rsp_flags_ff, rsp_flags_in;
   logic [fsp_pkg::FM_W-1:0]    float_mode_ff, float_mode_in;
   logic [fsp_pkg::IM_W-1:0]    int_mode_ff, int_mode_in;
   logic [fsp_pkg::ACC_W-1:0]   width_ff, width_in;
   logic [fsp_pkg::PREC_W-1:0]  precision_ff, precision_in;

   logic                        accept;
   logic                        is_digit;
   logic [fsp_pkg::DIGIT_W-1:0] digit;
   logic [fsp_pkg::ACC_W-1:0]   mac_acc;
   logic [fsp_pkg::ACC_W-1:0]   mac_result;
   logic                        finish;
   logic [fsp_pkg::PREC_W-1:0]  finish_prec;
   fsp_pkg::type_info_type      type_info;

   fsp_type_dec u_type_dec (
      .character (req_ch.character),
      .info      (type_info)
   );

   assign mac_acc = (phase_ff == fsp_pkg::PH_PREC) ? prec_acc_ff : width_acc_ff;

   fsp_sat_mac u_sat_mac (
      .acc    (mac_acc),
      .digit  (digit),
      .result (mac_result)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_digit     = (req_ch.character >= fsp_pkg::CH_ZERO)
                         && (req_ch.character <= fsp_pkg::CH_NINE);
   assign digit        = req_ch.character[fsp_pkg::DIGIT_W-1:0];

   // parse state update
   always_comb begin
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      width_acc_in = width_acc_ff;
      prec_acc_in  = prec_acc_ff;
      finish       = 1'b0;
      finish_prec  = '0;
      case (phase_ff)
         fsp_pkg::PH_FLAGS: begin
            if (req_ch.character == fsp_pkg::CH_SPACE) begin
               flags_in.pad = 1'b1;
            end else if (req_ch.character == fsp_pkg::CH_MINUS) begin
               flags_in.pad  = 1'b1;
               flags_in.left = 1'b1;
            end else if (req_ch.character == fsp_pkg::CH_ZERO) begin
               flags_in.zero = 1'b1;
            end else if (req_ch.character == fsp_pkg::CH_HASH) begin
               flags_in.full = 1'b1;
            end else if (is_digit) begin
               width_acc_in = {{(fsp_pkg::ACC_W-fsp_pkg::DIGIT_W){1'b0}}, digit};
               phase_in     = fsp_pkg::PH_WIDTH;
            end else if (req_ch.character == fsp_pkg::CH_DOT) begin
               phase_in = fsp_pkg::PH_DOT;
            end else begin
               finish = 1'b1;
            end
         end
         fsp_pkg::PH_WIDTH: begin
            if (is_digit) begin
               width_acc_in = mac_result;
            end else if (req_ch.character == fsp_pkg::CH_DOT) begin
               phase_in = fsp_pkg::PH_DOT;
            end else begin
               finish = 1'b1;
            end
         end
         fsp_pkg::PH_DOT: begin
            if (is_digit) begin
               prec_acc_in = {{(fsp_pkg::ACC_W-fsp_pkg::DIGIT_W){1'b0}}, digit};
               phase_in    = fsp_pkg::PH_PREC;
            end else begin
               finish      = 1'b1;
               finish_prec = '1;
            end
         end
         fsp_pkg::PH_PREC: begin
            if (is_digit) begin
               prec_acc_in = mac_result;
            end else begin
               finish      = 1'b1;
               finish_prec = {1'b0, prec_acc_ff};
            end
         end
         default: begin
            phase_in = fsp_pkg::PH_FLAGS;
         end
      endcase
      if (finish) begin
         phase_in     = fsp_pkg::PH_FLAGS;
         flags_in     = '0;
         width_acc_in = '0;
         prec_acc_in  = '0;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      ok_in         = ok_ff;
      rsp_flags_in  = rsp_flags_ff;
      float_mode_in = float_mode_ff;
      int_mode_in   = int_mode_ff;
      width_in      = width_ff;
      precision_in  = precision_ff;
      if (accept && finish) begin
         rsp_valid_in  = 1'b1;
         ok_in         = type_info.hit;
         rsp_flags_in  = '0;
         float_mode_in = '0;
         int_mode_in   = '0;
         width_in      = '0;
         precision_in  = '0;
         if (type_info.hit) begin
            rsp_flags_in      = flags_ff;
            rsp_flags_in.zero = flags_ff.zero | type_info.zero;
            rsp_flags_in.full = flags_ff.full | type_info.full;
            float_mode_in     = type_info.float_mode;
            int_mode_in       = type_info.int_mode;
            width_in          = width_acc_ff;
            precision_in      = finish_prec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fsp_pkg::PH_FLAGS;
         flags_ff     <= '0;
         width_acc_ff <= '0;
         prec_acc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            flags_ff     <= flags_in;
            width_acc_ff <= width_acc_in;
            prec_acc_ff  <= prec_acc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff         <= ok_in;
      rsp_flags_ff  <= rsp_flags_in;
      float_mode_ff <= float_mode_in;
      int_mode_ff   <= int_mode_in;
      width_ff      <= width_in;
      precision_ff  <= precision_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ok            = ok_ff;
   assign rsp_ch.pad_mark      = rsp_flags_ff.pad;
   assign rsp_ch.left_align    = rsp_flags_ff.left;
   assign rsp_ch.zero_fill     = rsp_flags_ff.zero;
   assign rsp_ch.full_notation = rsp_flags_ff.full;
   assign rsp_ch.float_mode    = float_mode_ff;
   assign rsp_ch.int_mode      = int_mode_ff;
   assign rsp_ch.width         = width_ff;
   assign rsp_ch.precision     = precision_ff;

   a_fail_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> rsp_flags_ff == '0 && width_ff == '0
                                 && precision_ff == '0 && float_mode_ff == '0
                                 && int_mode_ff == '0)
      else $error("failed specifier carries nonzero fields");

   a_finish_clears_state: assert property (@(posedge clock) disable iff (reset)
      accept && finish |=> phase_ff == fsp_pkg::PH_FLAGS && flags_ff == '0
                           && width_acc_ff == '0 && prec_acc_ff == '0)
      else $error("parse state not cleared after ending character");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while response is stalled");

   a_neg_prec_only_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && precision_ff[fsp_pkg::PREC_W-1] |-> precision_ff == '1)
      else $error("negative precision other than empty");

endmodule

[bench/tb_top.sv]
// Testbench for format_spec_parser: character streams of printf-style specifiers
// in, parsed specifier fields out, checked against an in-bench parser model.
// Depends on fsp_pkg, fsp_if and the format_spec_parser RTL.
module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TARGET_CHARS = 1400;
   localparam int IDLE_PCT     = 26;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 60;
   localparam int CALM_FROM    = 500;
   localparam int CALM_TO      = 800;
   localparam int DRAIN_AT     = 1000;

   typedef struct {
      logic                                 ok;
      logic                                 pad;
      logic                                 left;
      logic                                 zero;
      logic                                 full;
      fsp_pkg::float_mode_type              fm;
      fsp_pkg::int_mode_type                im;
      logic [fsp_pkg::ACC_W-1:0]            width;
      logic signed [fsp_pkg::PREC_W-1:0]    precision;
   } spec_fields_type;

   logic clock;
   logic reset;

   fsp_req_if req_bus();
   fsp_rsp_if rsp_bus();

   format_spec_parser u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   logic [fsp_pkg::CHAR_W-1:0] pending_chars[$];
   spec_fields_type            expected_specs[$];

   fsp_pkg::phase_type         spec_phase;
   fsp_pkg::flags_type         spec_flags;
   logic [fsp_pkg::ACC_W-1:0]  width_acc;
   logic [fsp_pkg::ACC_W-1:0]  prec_acc;

   int chars_taken;
   int hold_left;
   bit hold_done;
   bit drain_done;
   int cycles;
   int errors;
   int specs_seen;
   int specs_ok;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.character = '0;
      rsp_bus.ready = 1'b0;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got)
         report($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   function automatic logic [fsp_pkg::ACC_W-1:0] push_digit(
      input logic [fsp_pkg::ACC_W-1:0] acc,
      input logic [3:0] d);
      int unsigned v;
      v = acc * 10 + d;
      return (v > fsp_pkg::ACC_SAT) ? fsp_pkg::ACC_SAT : v[fsp_pkg::ACC_W-1:0];
   endfunction

   function automatic fsp_pkg::type_info_type decode_type(
      input logic [fsp_pkg::CHAR_W-1:0] ch);
      fsp_pkg::type_info_type info;
      info = '{hit: 1'b1, float_mode: fsp_pkg::FM_FIXED, int_mode: fsp_pkg::IM_DECIMAL,
               zero: 1'b0, full: 1'b0};
      case (ch)
         "d", "i", "u", "s", "c", "f": ;
         "F": info.float_mode = fsp_pkg::FM_FIXED_REL;
         "e": info.float_mode = fsp_pkg::FM_EXPONENT;
         "E": info.float_mode = fsp_pkg::FM_ENGINEER;
         "g": info.float_mode = fsp_pkg::FM_SMART;
         "G": info.float_mode = fsp_pkg::FM_COMPACT;
         "a", "x": info.int_mode = fsp_pkg::IM_HEX;
         "p": begin
            info.int_mode = fsp_pkg::IM_HEX;
            info.zero = 1'b1;
            info.full = 1'b1;
         end
         "o": info.int_mode = fsp_pkg::IM_OCTAL;
         "b": info.int_mode = fsp_pkg::IM_BINARY;
         default: info.hit = 1'b0;
      endcase
      return info;
   endfunction

   task automatic clear_spec();
      spec_phase = fsp_pkg::PH_FLAGS;
      spec_flags = '0;
      width_acc  = '0;
      prec_acc   = '0;
   endtask

   task automatic close_spec(input logic [fsp_pkg::CHAR_W-1:0] ch,
                             input logic signed [fsp_pkg::PREC_W-1:0] prec);
      fsp_pkg::type_info_type info;
      spec_fields_type        r;
      info = decode_type(ch);
      r = '{ok: 1'b0, pad: 1'b0, left: 1'b0, zero: 1'b0, full: 1'b0,
            fm: fsp_pkg::FM_FIXED, im: fsp_pkg::IM_DECIMAL, width: '0, precision: '0};
      if (info.hit) begin
         r.ok        = 1'b1;
         r.pad       = spec_flags.pad;
         r.left      = spec_flags.left;
         r.zero      = spec_flags.zero | info.zero;
         r.full      = spec_flags.full | info.full;
         r.fm        = info.float_mode;
         r.im        = info.int_mode;
         r.width     = width_acc;
         r.precision = prec;
      end
      expected_specs.push_back(r);
      clear_spec();
   endtask

   task automatic parse_char(input logic [fsp_pkg::CHAR_W-1:0] ch);
      logic       is_digit;
      logic [3:0] d;
      is_digit = (ch >= fsp_pkg::CH_ZERO) && (ch <= fsp_pkg::CH_NINE);
      d = 4'(ch - fsp_pkg::CH_ZERO);
      case (spec_phase)
         fsp_pkg::PH_FLAGS: begin
            if (ch == fsp_pkg::CH_SPACE) spec_flags.pad = 1'b1;
            else if (ch == fsp_pkg::CH_MINUS) begin
               spec_flags.pad  = 1'b1;
               spec_flags.left = 1'b1;
            end
            else if (ch == fsp_pkg::CH_ZERO) spec_flags.zero = 1'b1;
            else if (ch == fsp_pkg::CH_HASH) spec_flags.full = 1'b1;
            else if (is_digit) begin
               width_acc  = fsp_pkg::ACC_W'(d);
               spec_phase = fsp_pkg::PH_WIDTH;
            end
            else if (ch == fsp_pkg::CH_DOT) spec_phase = fsp_pkg::PH_DOT;
            else close_spec(ch, '0);
         end
         fsp_pkg::PH_WIDTH: begin
            if (is_digit) width_acc = push_digit(width_acc, d);
            else if (ch == fsp_pkg::CH_DOT) spec_phase = fsp_pkg::PH_DOT;
            else close_spec(ch, '0);
         end
         fsp_pkg::PH_DOT: begin
            if (is_digit) begin
               prec_acc   = fsp_pkg::ACC_W'(d);
               spec_phase = fsp_pkg::PH_PREC;
            end
            else close_spec(ch, '1);
         end
         default: begin
            if (is_digit) prec_acc = push_digit(prec_acc, d);
            else close_spec(ch, {1'b0, prec_acc});
         end
      endcase
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         pending_chars.push_back(s[i]);
   endtask

   task automatic push_digits(input int count, input bit nonzero_first);
      for (int i = 0; i < count; i++) begin
         if (i == 0 && nonzero_first)
            pending_chars.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
         else
            pending_chars.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
   endtask

   task automatic gen_specifier();
      string                      type_chars;
      logic [fsp_pkg::CHAR_W-1:0] flag_chars[4];
      int                         r;
      int                         n;
      type_chars = "diuscfFeEgGaxpob";
      flag_chars = '{fsp_pkg::CH_SPACE, fsp_pkg::CH_MINUS, fsp_pkg::CH_ZERO,
                     fsp_pkg::CH_HASH};
      r = $urandom_range(0, 99);
      if (r < 8) begin
         pending_chars.push_back(8'($urandom_range(0, 255)));
         return;
      end
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         pending_chars.push_back(flag_chars[$urandom_range(0, 3)]);
      r = $urandom_range(0, 99);
      if (r >= 30)
         push_digits((r >= 90) ? $urandom_range(5, 7) : $urandom_range(1, 3), 1'b1);
      if ($urandom_range(0, 1) == 1) begin
         pending_chars.push_back(fsp_pkg::CH_DOT);
         r = $urandom_range(0, 99);
         if (r >= 25)
            push_digits((r >= 90) ? $urandom_range(5, 7) : $urandom_range(1, 3), 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 85)
         pending_chars.push_back(type_chars[$urandom_range(0, type_chars.len() - 1)]);
      else if (r < 95)
         pending_chars.push_back(8'($urandom_range(0, 255)));
      else
         pending_chars.push_back(flag_chars[$urandom_range(0, 3)]);
   endtask

   // request driver: predicts on each transfer, then offers the next character
   always @(posedge clock) begin : drive_proc
      bit hold;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.character <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            parse_char(req_bus.character);
            chars_taken <= chars_taken + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            hold = ($urandom_range(0, 99) < IDLE_PCT) &&
                   !(chars_taken >= CALM_FROM && chars_taken < CALM_TO);
            if (!drain_done && chars_taken >= DRAIN_AT) begin
               if (expected_specs.size() == 0) drain_done = 1'b1;
               else hold = 1'b1;
            end
            if (!hold && pending_chars.size() != 0) begin
               req_bus.valid     <= 1'b1;
               req_bus.character <= pending_chars.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // one long response hold-off so the output register fills and stalls input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && chars_taken >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin : watch_proc
      spec_fields_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_specs.size() == 0) begin
               report($sformatf("response with none pending, ok=%0d width=%0d",
                                rsp_bus.ok, rsp_bus.width));
            end else begin
               e = expected_specs.pop_front();
               specs_seen++;
               if (e.ok) specs_ok++;
               check_field("ok", int'(e.ok), int'(rsp_bus.ok));
               check_field("pad_mark", int'(e.pad), int'(rsp_bus.pad_mark));
               check_field("left_align", int'(e.left), int'(rsp_bus.left_align));
               check_field("zero_fill", int'(e.zero), int'(rsp_bus.zero_fill));
               check_field("full_notation", int'(e.full), int'(rsp_bus.full_notation));
               check_field("float_mode", int'(e.fm), int'(rsp_bus.float_mode));
               check_field("int_mode", int'(e.im), int'(rsp_bus.int_mode));
               check_field("width", int'(e.width), int'(rsp_bus.width));
               check_field("precision", int'(e.precision), int'(rsp_bus.precision));
            end
         end
         rsp_bus.ready <= (hold_left == 0) &&
                          !(($urandom_range(0, 99) < IDLE_PCT) &&
                            !(chars_taken >= CALM_FROM && chars_taken < CALM_TO));
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      chars_taken = 0;
      errors      = 0;
      specs_seen  = 0;
      specs_ok    = 0;
      cycles      = 0;
      drain_done  = 1'b0;
      clear_spec();

      // flag runs with repeated zero, bare dot, flag after width and after
      // precision, NUL, high byte, pointer type, width overflow
      push_text(" -#00.G");
      push_text("1#");
      push_text(".5-");
      pending_chars.push_back(8'h00);
      pending_chars.push_back(8'hFF);
      push_text("p");
      push_text("99999b");
      push_text("F");
      push_text("E");
      push_text("o");
      while (pending_chars.size() < TARGET_CHARS)
         gen_specifier();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (expected_specs.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("%0d characters sent, %0d specifiers checked (%0d accepted, %0d rejected)",
               chars_taken, specs_seen, specs_ok, specs_seen - specs_ok);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
